>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> sv/tmrc_pkg.sv
// Types, constants and helper functions of the radix converter.
package tmrc_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int OUT_BITS    = 32;
  localparam int DIGIT_W     = 6;
  localparam int RADIX_MIN   = 2;
  localparam int RADIX_MAX   = 36;
  localparam int RADIX_COUNT = RADIX_MAX - RADIX_MIN + 1;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] LETTER_BASE = 8'd10;

  typedef logic [VALUE_BITS-1:0] acc_t;
  typedef logic [DIGIT_W-1:0]    digit_t;

  typedef struct packed {
    logic upd;
    logic clr;
  } cell_ctl_t;

  typedef struct packed {
    logic   emit;
    digit_t radix;
    logic   neg;
  } emit_t;

  typedef struct packed {
    logic   valid;
    digit_t digit;
  } digit_info_t;

  // Classify one byte: letters are worth 10..35, digits 0..9.
  function automatic digit_info_t digit_of(logic [7:0] b);
    digit_info_t r;
    r.valid = 1'b1;
    if (b >= CH_0 && b <= CH_9) begin
      r.digit = DIGIT_W'(b - CH_0);
    end else if (b >= CH_LA && b <= CH_LZ) begin
      r.digit = DIGIT_W'(b - CH_LA + LETTER_BASE);
    end else if (b >= CH_UA && b <= CH_UZ) begin
      r.digit = DIGIT_W'(b - CH_UA + LETTER_BASE);
    end else begin
      r.valid = 1'b0;
      r.digit = '0;
    end
    return r;
  endfunction

endpackage

>>> sv/tmrc_if.sv
// Valid/ready channel interfaces for text input and conversion results.
interface tmrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source(output valid, output text_byte, output end_of_text, input ready);
  modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

interface tmrc_out_if;
  logic                                valid;
  logic                                ready;
  logic [tmrc_pkg::DIGIT_W-1:0]        radix;
  logic signed [tmrc_pkg::OUT_BITS-1:0] value;

  modport source(output valid, output radix, output value, input ready);
  modport sink(input valid, input radix, input value, output ready);
endinterface

>>> sv/token_min_radix_converter_core.sv
// Top level of the minimal-radix token converter.
// Usage:
//   in_ch  (sink)   : one text byte per request, with end_of_text on the final byte.
//   out_ch (source) : one request per finished run of letters and digits, carrying
//                     the smallest radix (2..36) and the run value, sign applied,
//                     wrapped to 32 bits.
// A run closes on the first byte that is not a letter or digit, or after a byte
// that carries end_of_text. A minus sign directly before a run makes it negative.
// Throughput: one byte per cycle while in_ch.ready is high, set by the row of 35
// accumulator cells that all take their multiply-add in the same cycle.
// Result path: once the closing byte is taken, a result passes the pending stage
// (readout chain and negation), then the output register.
// Stall: the output register holds while out_ch.ready is low; one more result
// waits in the pending stage, and in_ch.ready drops only once both are full.
// Reset: synchronous, active low; clears run state and empties both stages.
module token_min_radix_converter_core (
  input logic      clk,
  input logic      rst_n,
  tmrc_in_if.sink  in_ch,
  tmrc_out_if.source out_ch
);

  logic                accept;
  logic                out_free;
  logic                move;
  tmrc_pkg::cell_ctl_t ctl;
  tmrc_pkg::digit_t    digit;
  tmrc_pkg::emit_t     emit_info;

  logic                pend_r, pend_nxt;
  tmrc_pkg::digit_t    pend_radix_r;
  logic                pend_neg_r;

  logic                                  out_valid_r, out_valid_nxt;
  tmrc_pkg::digit_t                      out_radix_r;
  logic signed [tmrc_pkg::OUT_BITS-1:0]  out_value_r;

  tmrc_pkg::digit_t radix_link [0:tmrc_pkg::RADIX_COUNT];
  tmrc_pkg::acc_t   sel_link   [0:tmrc_pkg::RADIX_COUNT];
  tmrc_pkg::acc_t   sel_value;
  tmrc_pkg::acc_t   signed_value;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign move        = pend_r && out_free;
  assign in_ch.ready = !pend_r || out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  tmrc_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .text_byte   (in_ch.text_byte),
    .end_of_text (in_ch.end_of_text),
    .ctl         (ctl),
    .digit       (digit),
    .emit_info   (emit_info)
  );

  assign radix_link[0] = tmrc_pkg::DIGIT_W'(tmrc_pkg::RADIX_MIN);
  assign sel_link[0]   = '0;

  for (genvar k = 0; k < tmrc_pkg::RADIX_COUNT; k++) begin : g_cell
    tmrc_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .digit     (digit),
      .radix_in  (radix_link[k]),
      .sel_radix (pend_radix_r),
      .sel_in    (sel_link[k]),
      .radix_out (radix_link[k+1]),
      .sel_out   (sel_link[k+1])
    );
  end

  assign sel_value    = sel_link[tmrc_pkg::RADIX_COUNT];
  assign signed_value = pend_neg_r ? tmrc_pkg::acc_t'('0 - sel_value) : sel_value;

  // Hold a pending result until the output register frees up.
  always_comb begin
    pend_nxt = pend_r;
    if (move) begin
      pend_nxt = 1'b0;
    end
    if (emit_info.emit) begin
      pend_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_info.emit) begin
      pend_radix_r <= emit_info.radix;
      pend_neg_r   <= emit_info.neg;
    end
    if (move) begin
      out_radix_r <= pend_radix_r;
      out_value_r <= tmrc_pkg::OUT_BITS'(signed'(signed_value));
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.radix = out_radix_r;
  assign out_ch.value = out_value_r;

endmodule

>>> sv/tmrc_cell.sv
// One accumulator cell: run value in one radix, plus its slot of the readout chain.
module tmrc_cell (
  input  logic                clk,
  input  tmrc_pkg::cell_ctl_t ctl,
  input  tmrc_pkg::digit_t    digit,
  input  tmrc_pkg::digit_t    radix_in,
  input  tmrc_pkg::digit_t    sel_radix,
  input  tmrc_pkg::acc_t      sel_in,
  output tmrc_pkg::digit_t    radix_out,
  output tmrc_pkg::acc_t      sel_out
);

  tmrc_pkg::acc_t acc_r;
  tmrc_pkg::acc_t acc_nxt;
  tmrc_pkg::acc_t acc_base;

  // Start of a run drops the old value before the multiply-add.
  assign acc_base = ctl.clr ? '0 : acc_r;
  assign acc_nxt  = acc_base * tmrc_pkg::acc_t'(radix_in) + tmrc_pkg::acc_t'(digit);

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      acc_r <= acc_nxt;
    end
  end

  // The next cell works in the next radix.
  assign radix_out = radix_in + tmrc_pkg::DIGIT_W'(1);
  assign sel_out   = (radix_in == sel_radix) ? acc_r : sel_in;

endmodule

>>> sv/tmrc_scan.sv
// Tokenizer: run boundaries, sign, largest digit and cell control.
module tmrc_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          text_byte,
  input  logic                end_of_text,
  output tmrc_pkg::cell_ctl_t ctl,
  output tmrc_pkg::digit_t    digit,
  output tmrc_pkg::emit_t     emit_info
);

  logic                  inside_r, inside_nxt;
  logic                  prev_minus_r, prev_minus_nxt;
  logic                  run_neg_r, run_neg_nxt;
  tmrc_pkg::digit_t      largest_r, largest_nxt;
  tmrc_pkg::digit_info_t info;
  tmrc_pkg::digit_t      largest_base;
  tmrc_pkg::digit_t      largest_eff;
  logic                  neg_eff;

  assign info  = tmrc_pkg::digit_of(text_byte);
  assign digit = info.digit;

  assign ctl.upd = accept && info.valid;
  assign ctl.clr = !inside_r;

  always_comb begin
    largest_base = inside_r ? largest_r : '0;
    if (info.valid) begin
      largest_eff = (info.digit > largest_base) ? info.digit : largest_base;
      neg_eff     = inside_r ? run_neg_r : prev_minus_r;
    end else begin
      largest_eff = largest_r;
      neg_eff     = run_neg_r;
    end

    // A run closes on a separator, or on a digit that ends the text.
    emit_info.emit  = accept && ((!info.valid && inside_r) || (info.valid && end_of_text));
    emit_info.radix = (largest_eff == '0) ? tmrc_pkg::DIGIT_W'(tmrc_pkg::RADIX_MIN)
                                          : largest_eff + tmrc_pkg::DIGIT_W'(1);
    emit_info.neg   = neg_eff;

    inside_nxt     = inside_r;
    prev_minus_nxt = prev_minus_r;
    run_neg_nxt    = run_neg_r;
    largest_nxt    = largest_r;
    if (accept) begin
      inside_nxt     = info.valid && !end_of_text;
      prev_minus_nxt = (text_byte == tmrc_pkg::CH_MINUS) && !end_of_text;
      run_neg_nxt    = neg_eff;
      largest_nxt    = largest_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r     <= 1'b0;
      prev_minus_r <= 1'b0;
      run_neg_r    <= 1'b0;
      largest_r    <= '0;
    end else begin
      inside_r     <= inside_nxt;
      prev_minus_r <= prev_minus_nxt;
      run_neg_r    <= run_neg_nxt;
      largest_r    <= largest_nxt;
    end
  end

endmodule

>>> sv/tmrc_checker.sv
// Port-level checker for the radix converter, bound to the top level.
`include "assert_macros.svh"

module tmrc_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [tmrc_pkg::DIGIT_W-1:0]         out_radix,
  input logic signed [tmrc_pkg::OUT_BITS-1:0] out_value
);

  localparam logic [tmrc_pkg::DIGIT_W-1:0] RADIX_LO = tmrc_pkg::DIGIT_W'(tmrc_pkg::RADIX_MIN);
  localparam logic [tmrc_pkg::DIGIT_W-1:0] RADIX_HI = tmrc_pkg::DIGIT_W'(tmrc_pkg::RADIX_MAX);

  // A stalled result stays up with the same payload.
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid)
  `ASSERT_CLK(a_out_stable, out_valid && !out_ready |=> $stable(out_radix) && $stable(out_value))
  // Every reported radix is in the legal span.
  `ASSERT_CLK(a_radix_range, out_valid |-> (out_radix >= RADIX_LO) && (out_radix <= RADIX_HI))
  // An empty output register never blocks the input.
  `ASSERT_CLK(a_ready_when_empty, !out_valid |-> in_ready)
  // Reset empties the output stage.
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind token_min_radix_converter_core tmrc_checker u_tmrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_radix (out_ch.radix),
  .out_value (out_ch.value)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the minimal-radix token converter: directed table, then random text.
module tb;
  import tmrc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int PAUSE_AT     = 900;
  localparam int CALM_FROM    = 1600;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [DIGIT_W-1:0]         radix;
    logic signed [OUT_BITS-1:0] value;
  } run_result_t;

  typedef struct {
    logic [7:0]  ch;
    logic        eot;
    bit          typed;
    run_result_t res;
  } text_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   errors = 0;
  int   sent = 0;
  bit   calm = 1'b0;

  // predictor state
  acc_t   radix_sums [RADIX_COUNT];
  digit_t top_digit;
  bit     open_run;
  bit     last_minus;
  bit     open_negative;

  run_result_t expected_runs[$];
  text_row_t   script[$];

  tmrc_in_if  in_ch();
  tmrc_out_if out_ch();

  token_min_radix_converter_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("token_min_radix_converter_core regression: fail");
      $finish;
    end
  end

  // Work out the run result, if any, that one text byte closes.
  task automatic predict_run(input logic [7:0] b, input logic eot,
                             output bit got, output run_result_t res);
    int   w;
    int   r;
    acc_t v;
    w = -1;
    got = 1'b0;
    res = '0;
    if (b >= CH_0 && b <= CH_9) w = int'(b - CH_0);
    else if (b >= CH_LA && b <= CH_LZ) w = int'(b - CH_LA) + 10;
    else if (b >= CH_UA && b <= CH_UZ) w = int'(b - CH_UA) + 10;
    if (w >= 0) begin
      if (!open_run) begin
        for (int i = 0; i < RADIX_COUNT; i++) radix_sums[i] = '0;
        top_digit = '0;
        open_negative = last_minus;
        open_run = 1'b1;
      end
      for (int i = 0; i < RADIX_COUNT; i++)
        radix_sums[i] = acc_t'(radix_sums[i] * acc_t'(i + RADIX_MIN) + acc_t'(w));
      if (w > int'(top_digit)) top_digit = digit_t'(w);
    end
    // close on a separator, or after the final byte of the text
    if (open_run && (w < 0 || eot)) begin
      r = int'(top_digit) + 1;
      if (r < RADIX_MIN) r = RADIX_MIN;
      if (r > RADIX_MAX) r = RADIX_MAX;
      v = radix_sums[r - RADIX_MIN];
      if (open_negative) v = acc_t'(-v);
      got = 1'b1;
      res.radix = DIGIT_W'(r);
      res.value = OUT_BITS'($signed(v));
      open_run = 1'b0;
    end
    last_minus = (b == CH_MINUS) && !eot;
  endtask

  task automatic send_text(input logic [7:0] b, input logic eot, input bit typed,
                           input run_result_t typed_res);
    bit          got;
    run_result_t res;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= b;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_run(b, eot, got, res);
    if (typed) expected_runs.push_back(typed_res);
    else if (got) expected_runs.push_back(res);
    sent++;
  endtask

  task automatic add_row(input logic [7:0] ch, input logic eot, input bit typed,
                         input int radix, input int value);
    text_row_t row;
    row.ch = ch;
    row.eot = eot;
    row.typed = typed;
    row.res.radix = DIGIT_W'(radix);
    row.res.value = OUT_BITS'(value);
    script.push_back(row);
  endtask

  // Optional minus, a run of letters and digits, then a separator or end of text.
  task automatic send_token();
    int         len;
    int         ceil_digit;
    int         d;
    logic [7:0] c;
    logic       eot;
    eot = 1'b0;
    if ($urandom_range(0, 2) == 0) send_text(CH_MINUS, 1'b0, 1'b0, '0);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    ceil_digit = $urandom_range(0, 35);
    for (int k = 0; k < len; k++) begin
      d = $urandom_range(0, ceil_digit);
      if (d < 10) c = CH_0 + 8'(d);
      else if ($urandom_range(0, 1) == 1) c = CH_LA + 8'(d - 10);
      else c = CH_UA + 8'(d - 10);
      eot = (k == len - 1) && ($urandom_range(0, 9) == 0);
      send_text(c, eot, 1'b0, '0);
    end
    if (!eot) begin
      case ($urandom_range(0, 4))
        0: c = 8'h20;
        1: c = CH_MINUS;
        2: c = 8'h00;
        3: c = 8'($urandom_range(128, 255));
        default: c = 8'($urandom_range(8'h21, 8'h2f));
      endcase
      send_text(c, ($urandom_range(0, 7) == 0), 1'b0, '0);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      send_text(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0), 1'b0, '0);
  endtask

  initial begin : sink_ready
    int stretch;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      stretch = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      repeat (stretch) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    run_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_runs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual radix %0d value %0d",
                 $time, out_ch.radix, out_ch.value);
      end else begin
        want = expected_runs.pop_front();
        if (out_ch.radix !== want.radix) begin
          errors++;
          $display("%0t: radix mismatch: expected %0d, actual %0d",
                   $time, want.radix, out_ch.radix);
        end
        if (out_ch.value !== want.value) begin
          errors++;
          $display("%0t: value mismatch: expected %0d, actual %0d",
                   $time, want.value, out_ch.value);
        end
      end
    end
  end

  initial begin : stimulus
    bit paused;
    paused = 1'b0;
    for (int i = 0; i < RADIX_COUNT; i++) radix_sums[i] = '0;
    top_digit = '0;
    open_run = 1'b0;
    last_minus = 1'b0;
    open_negative = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.text_byte = '0;
    in_ch.end_of_text = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    add_row("0", 1'b1, 1'b1, 2, 0);
    // negative zero
    add_row(CH_MINUS, 1'b0, 1'b0, 0, 0);
    add_row("0", 1'b1, 1'b1, 2, 0);
    // NUL and high bytes only separate
    add_row("1", 1'b0, 1'b0, 0, 0);
    add_row(8'h00, 1'b0, 1'b1, 2, 1);
    add_row("z", 1'b1, 1'b1, 36, 35);
    add_row(CH_MINUS, 1'b0, 1'b0, 0, 0);
    add_row("Z", 1'b0, 1'b0, 0, 0);
    add_row(8'hff, 1'b0, 1'b1, 36, -35);
    add_row("9", 1'b0, 1'b0, 0, 0);
    add_row(8'h80, 1'b0, 1'b1, 10, 9);
    // minus that does not touch the run
    add_row(CH_MINUS, 1'b0, 1'b0, 0, 0);
    add_row(8'h20, 1'b0, 1'b0, 0, 0);
    add_row("a", 1'b1, 1'b1, 11, 10);
    // wraps past 32 bits in radix 36
    repeat (6) add_row("z", 1'b0, 1'b0, 0, 0);
    add_row("z", 1'b1, 1'b0, 0, 0);
    // mixed case; the closing minus makes the next run negative
    add_row("a", 1'b0, 1'b0, 0, 0);
    add_row("Z", 1'b0, 1'b0, 0, 0);
    add_row("9", 1'b0, 1'b0, 0, 0);
    add_row(CH_MINUS, 1'b0, 1'b0, 0, 0);
    add_row("Q", 1'b1, 1'b0, 0, 0);

    foreach (script[i]) send_text(script[i].ch, script[i].eot, script[i].typed, script[i].res);

    while (sent < script.size() + RANDOM_ITEMS) begin
      if (!paused && sent >= PAUSE_AT) begin
        // hold the input until every pending result has drained
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_runs.size() != 0);
        paused = 1'b1;
      end
      calm = (sent >= CALM_FROM);
      if ($urandom_range(0, 5) == 0) send_noise();
      else send_token();
    end

    in_ch.valid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_runs.size() == 0) begin
      $display("token_min_radix_converter_core regression: pass");
    end else begin
      $display("token_min_radix_converter_core regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/tmrc_pkg.sv
sv/tmrc_if.sv
sv/tmrc_cell.sv
sv/tmrc_scan.sv
sv/token_min_radix_converter_core.sv
sv/tmrc_checker.sv
test/tb.sv
